@@ src/asb_pkg.sv @@
// Shared types and constants for the Annex B stream splitter.
// Used by asb_scan, asb_outq and annexb_stream_splitter; depends on nothing.
package asb_pkg;

	// Width of internal byte offsets, and width of reported offsets and lengths.
	localparam int OFF_W = 24;
	localparam int SEG_W = 24;

	// Result queue depth; one byte can push two results.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes.
	localparam logic CFG_SPLIT_MODE = 1'b0;
	localparam logic CFG_SKIP_TO_SPS = 1'b1;

	// Split modes.
	localparam logic MODE_NAL = 1'b0;
	localparam logic MODE_AU = 1'b1;

	// NAL unit types that the scanner looks for.
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_AUD = 5'd9;

	// Report status codes.
	localparam logic [1:0] ST_SEG = 2'd0;
	localparam logic [1:0] ST_NO_SPS = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	// Parse phase of the current buffer.
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_SEEK = 2'd1,
		PH_SPLIT = 2'd2
	} phase_t;

	// Configuration register contents.
	typedef struct packed {
		logic split_mode;
		logic skip_to_sps;
	} cfg_t;

	// One reported result.
	typedef struct packed {
		logic [SEG_W-1:0] start;
		logic [SEG_W-1:0] length;
		logic [1:0] status;
		logic last;
	} result_t;

	// Results caused by one byte, packed from r0.
	typedef struct packed {
		logic [1:0] count;
		result_t r0;
		result_t r1;
	} res_pair_t;

endpackage

@@ src/asb_scan.sv @@
// Start code scanner: window, offset and segment state, and the per-byte result logic.
// Depends on asb_pkg.
module asb_scan (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] data_byte,
	input logic end_of_buffer,
	input asb_pkg::cfg_t cfg,
	output asb_pkg::res_pair_t res
);

	logic [31:0] window_q;
	logic [asb_pkg::OFF_W-1:0] offset_q;
	logic [asb_pkg::OFF_W-1:0] begin_q;
	logic [asb_pkg::OFF_W-1:0] floor_q;
	asb_pkg::phase_t phase_q;

	logic [39:0] win;
	logic [7:0] b0, b1, b2, b3, bp;
	logic [asb_pkg::OFF_W-1:0] w, w_back, len;
	logic have_win, prev_zero, is_sps, is_aud, is_nal;
	asb_pkg::phase_t ph_n;
	logic [asb_pkg::OFF_W-1:0] sb_n, sf_n, cut;
	logic hit, cut_v, end_v;
	asb_pkg::result_t r_cut, r_end;

	// Per-byte evaluation of the current window against the state.
	always_comb begin
		win = {window_q, data_byte};
		bp = win[39:32];
		b0 = win[31:24];
		b1 = win[23:16];
		b2 = win[15:8];
		b3 = win[7:0];
		have_win = offset_q >= asb_pkg::OFF_W'(3);
		w = offset_q - asb_pkg::OFF_W'(3);
		w_back = w - asb_pkg::OFF_W'(1);
		prev_zero = (w != '0) && (bp == 8'h00);
		is_sps = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01) && (b3[4:0] == asb_pkg::NAL_SPS);
		is_aud = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01) && (b3[4:0] == asb_pkg::NAL_AUD);
		is_nal = ((b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01)) ||
			((b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h00) && (b3 == 8'h01));
		len = offset_q + asb_pkg::OFF_W'(1);

		ph_n = phase_q;
		sb_n = begin_q;
		sf_n = floor_q;
		hit = 1'b0;
		cut = w;
		cut_v = 1'b0;

		// First byte of a buffer picks the starting phase.
		if (phase_q == asb_pkg::PH_START) begin
			sb_n = '0;
			if (cfg.skip_to_sps) begin
				ph_n = asb_pkg::PH_SEEK;
				sf_n = '0;
			end else begin
				ph_n = asb_pkg::PH_SPLIT;
				sf_n = (cfg.split_mode == asb_pkg::MODE_AU) ? '0 : asb_pkg::OFF_W'(3);
			end
		end

		if (have_win) begin
			// The first SPS start code opens the first segment.
			if (ph_n == asb_pkg::PH_SEEK && is_sps) begin
				sb_n = prev_zero ? w_back : w;
				sf_n = sb_n + ((cfg.split_mode == asb_pkg::MODE_AU) ? '0 : asb_pkg::OFF_W'(3));
				ph_n = asb_pkg::PH_SPLIT;
			end

			// Cut at a start code, or only at an access unit delimiter in AU mode.
			if (ph_n == asb_pkg::PH_SPLIT && w >= sf_n) begin
				if (cfg.split_mode == asb_pkg::MODE_AU) begin
					hit = is_aud;
					if (prev_zero) begin
						cut = w_back;
					end
				end else begin
					hit = is_nal;
				end
				if (hit) begin
					if (cut < sb_n) begin
						cut = sb_n;
					end
					cut_v = cut > sb_n;
					sf_n = w + asb_pkg::OFF_W'(3);
				end
			end
		end

		r_cut.start = asb_pkg::SEG_W'(sb_n);
		r_cut.length = asb_pkg::SEG_W'(cut - sb_n);
		r_cut.status = asb_pkg::ST_SEG;
		r_cut.last = 1'b0;
		if (hit) begin
			sb_n = cut;
		end

		// End of buffer reports the tail segment or a status.
		end_v = 1'b0;
		r_end.start = asb_pkg::SEG_W'(sb_n);
		r_end.length = asb_pkg::SEG_W'(len - sb_n);
		r_end.status = asb_pkg::ST_SEG;
		r_end.last = 1'b1;
		if (end_of_buffer) begin
			if (len < asb_pkg::OFF_W'(4)) begin
				end_v = 1'b1;
				r_end.start = '0;
				r_end.length = asb_pkg::SEG_W'(len);
				r_end.status = asb_pkg::ST_SHORT;
			end else if (ph_n == asb_pkg::PH_SEEK) begin
				end_v = 1'b1;
				r_end.start = '0;
				r_end.length = asb_pkg::SEG_W'(len);
				r_end.status = asb_pkg::ST_NO_SPS;
			end else begin
				end_v = len > sb_n;
			end
		end
		r_cut.last = !end_v;

		res.count = {1'b0, cut_v} + {1'b0, end_v};
		res.r0 = cut_v ? r_cut : r_end;
		res.r1 = r_end;
	end

	// State update once per consumed byte; the buffer end clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			offset_q <= '0;
			begin_q <= '0;
			floor_q <= '0;
			phase_q <= asb_pkg::PH_START;
		end else if (step) begin
			if (end_of_buffer) begin
				window_q <= '0;
				offset_q <= '0;
				begin_q <= '0;
				floor_q <= '0;
				phase_q <= asb_pkg::PH_START;
			end else begin
				window_q <= win[31:0];
				offset_q <= len;
				begin_q <= sb_n;
				floor_q <= sf_n;
				phase_q <= ph_n;
			end
		end
	end

endmodule

@@ src/asb_outq.sv @@
// Result queue: takes up to two results a cycle and hands out one beat a cycle unless out_stall holds it.
// Depends on asb_pkg.
module asb_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input asb_pkg::res_pair_t res,
	output logic room,
	output logic out_valid,
	input logic out_stall,
	output asb_pkg::result_t head
);

	asb_pkg::result_t q_mem [asb_pkg::QDEPTH];
	logic [asb_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [asb_pkg::QCNT_W-1:0] cnt_q;
	logic [asb_pkg::QCNT_W-1:0] n_in;
	logic pop;

	// Room for a worst-case pair of results.
	assign room = cnt_q <= asb_pkg::QCNT_W'(asb_pkg::QDEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head = q_mem[rd_ptr_q];
	assign pop = out_valid && !out_stall;
	assign n_in = push ? asb_pkg::QCNT_W'(res.count) : '0;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && res.count != 2'd0) begin
			q_mem[wr_ptr_q] <= res.r0;
		end
		if (push && res.count == 2'd2) begin
			q_mem[wr_ptr_q + asb_pkg::QPTR_W'(1)] <= res.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + asb_pkg::QPTR_W'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + asb_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + n_in - asb_pkg::QCNT_W'(pop);
		end
	end

endmodule

@@ src/annexb_stream_splitter.sv @@
// Top level of the Annex B stream splitter: ports, config registers, input register.
// Depends on asb_pkg, asb_scan and asb_outq.
//
// Usage: bytes of a buffer arrive on the input channel (in_valid / in_stall,
// data_byte, end_of_buffer), one beat per byte, with end_of_buffer set on the
// final byte; the next beat starts a new buffer at offset 0. Each byte yields
// zero, one or two result beats on the output channel (out_valid / out_stall):
// seg_start and seg_length of a segment, or a status for a short buffer or a
// buffer without SPS; run_last marks the last result of a byte.
// The config port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
// write split_mode (index 0) and skip_to_sps (index 1) only while idle.
// Path: a byte is held in the input register; when the queue has room, its
// results are written into the result queue, whose head drives the output.
// Throughput: one byte per cycle while the queue has room, limited by the
// state update of the scanner once per byte; the two results of one byte leave
// as separate output beats, which a four-entry result queue absorbs.
// When the receiver stalls, the queue fills and in_stall rises once the queue
// has no room for two more results. Reset clears the config registers, the
// scan state and the queue.
module annexb_stream_splitter (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic end_of_buffer,
	output logic out_valid,
	input logic out_stall,
	output logic [asb_pkg::SEG_W-1:0] seg_start,
	output logic [asb_pkg::SEG_W-1:0] seg_length,
	output logic [1:0] report_status,
	output logic run_last
);

	asb_pkg::cfg_t cfg_q;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic eob_s1;
	logic room;
	logic advance;
	asb_pkg::res_pair_t res;
	asb_pkg::result_t head;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				asb_pkg::CFG_SPLIT_MODE: cfg_q.split_mode <= cfg_data;
				asb_pkg::CFG_SKIP_TO_SPS: cfg_q.skip_to_sps <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register; it drains whenever the queue can take two results.
	assign advance = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eob_s1 <= end_of_buffer;
		end
	end

	asb_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.data_byte(byte_s1),
		.end_of_buffer(eob_s1),
		.cfg(cfg_q),
		.res(res)
	);

	asb_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.res(res),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head(head)
	);

	// Output beat fields.
	assign seg_start = head.start;
	assign seg_length = head.length;
	assign report_status = head.status;
	assign run_last = head.last;

`ifndef NO_ASSERTIONS
	// A status report is always alone for its byte and starts at offset zero.
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_status != asb_pkg::ST_SEG |-> run_last && seg_start == '0)
		else $error("status result not last or not at offset zero");

	// Empty segments are never reported.
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_status == asb_pkg::ST_SEG |-> seg_length != '0)
		else $error("empty segment reported");

	// A held input byte is not dropped while the queue has no room for two results.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(eob_s1))
		else $error("held input byte lost");
`endif

endmodule
